>>> hdl/offset_to_file_line_column_defines.svh
// Assertion helpers used by the checker file.
`ifndef OFFSET_TO_FILE_LINE_COLUMN_DEFINES_SVH
`define OFFSET_TO_FILE_LINE_COLUMN_DEFINES_SVH

// Clocked assertion, off while reset is low.
`define OFLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A stalled item stays valid and keeps its payload.
`define OFLC_ASSERT_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

>>> hdl/oflc_pkg.sv
`timescale 1ns / 1ps

package oflc_pkg;

  localparam int OffsetBits  = 24;
  localparam int ByteBits    = 8;
  localparam int CmdBits     = 2;
  localparam int StatusBits  = 2;
  localparam int FileIdBits  = 4;
  localparam int LineNumBits = 13;
  localparam int ColumnBits  = 25;
  localparam int InDataBits  = 32;
  localparam int OutDataBits = 48;
  localparam int OutPadBits  = OutDataBits - ColumnBits - LineNumBits - FileIdBits;

  localparam int DefMaxFiles = 16;
  localparam int DefMaxLines = 4096;

  localparam logic [ByteBits-1:0] NewlineByte = 8'd10;

  typedef enum logic [CmdBits-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_FILE   = 2'd3
  } status_e;

  typedef struct packed {
    logic in_ready;
    logic latch;
    logic exec;
    logic fs_init;
    logic f_read_mid;
    logic f_read_last;
    logic f_cmp;
    logic set_nf;
    logic ls_init;
    logic l_read_mid;
    logic l_read_last;
    logic l_cmp;
    logic set_ok;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic srch_done;
    logic lo_zero;
    logic past_end;
    logic out_free;
  } ctrl_stat_t;

endpackage

>>> hdl/oflc_ram.sv
`timescale 1ns / 1ps

module oflc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/oflc_ctrl.sv
`timescale 1ns / 1ps

module oflc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  oflc_pkg::ctrl_stat_t   stat_i,
  output oflc_pkg::ctrl_cmd_t    ctrl_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b0_0000_0001,
    S_DECODE = 9'b0_0000_0010,
    S_FPROBE = 9'b0_0000_0100,
    S_FCMP   = 9'b0_0000_1000,
    S_FREC   = 9'b0_0001_0000,
    S_LPROBE = 9'b0_0010_0000,
    S_LCMP   = 9'b0_0100_0000,
    S_LREAD  = 9'b0_1000_0000,
    S_DONE   = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          oflc_pkg::CMD_BEGIN, oflc_pkg::CMD_BYTE: begin
            ctrl_o.exec = 1'b1;
            state_d     = S_DONE;
          end
          oflc_pkg::CMD_LOOKUP: begin
            ctrl_o.fs_init = 1'b1;
            state_d        = S_FPROBE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_FPROBE: begin
        if (stat_i.srch_done) begin
          if (stat_i.lo_zero) begin
            ctrl_o.set_nf = 1'b1;
            state_d       = S_DONE;
          end else begin
            ctrl_o.f_read_last = 1'b1;
            state_d            = S_FREC;
          end
        end else begin
          ctrl_o.f_read_mid = 1'b1;
          state_d           = S_FCMP;
        end
      end
      S_FCMP: begin
        ctrl_o.f_cmp = 1'b1;
        state_d      = S_FPROBE;
      end
      S_FREC: begin
        if (stat_i.past_end) begin
          ctrl_o.set_nf = 1'b1;
          state_d       = S_DONE;
        end else begin
          ctrl_o.ls_init = 1'b1;
          state_d        = S_LPROBE;
        end
      end
      S_LPROBE: begin
        if (stat_i.srch_done) begin
          ctrl_o.l_read_last = 1'b1;
          state_d            = S_LREAD;
        end else begin
          ctrl_o.l_read_mid = 1'b1;
          state_d           = S_LCMP;
        end
      end
      S_LCMP: begin
        ctrl_o.l_cmp = 1'b1;
        state_d      = S_LPROBE;
      end
      S_LREAD: begin
        ctrl_o.set_ok = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/oflc_dp.sv
`timescale 1ns / 1ps

module oflc_dp #(
  parameter int MAX_FILES = oflc_pkg::DefMaxFiles,
  parameter int MAX_LINES = oflc_pkg::DefMaxLines
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  oflc_pkg::ctrl_cmd_t                ctrl_i,
  output oflc_pkg::ctrl_stat_t               stat_o,
  input  logic [oflc_pkg::InDataBits-1:0]    in_data_i,
  input  logic [oflc_pkg::CmdBits-1:0]       in_user_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [oflc_pkg::OutDataBits-1:0]   out_data_o,
  output logic [oflc_pkg::StatusBits-1:0]    out_user_o
);

  localparam int OffW     = oflc_pkg::OffsetBits;
  localparam int FileIdxW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int FileCntW = $clog2(MAX_FILES + 1);
  localparam int LineIdxW = $clog2(MAX_LINES);
  localparam int LineCntW = $clog2(MAX_LINES + 1);
  localparam int SrchW    = (FileCntW > LineCntW) ? FileCntW : LineCntW;
  localparam int IdW      = oflc_pkg::FileIdBits;
  localparam int LnW      = oflc_pkg::LineNumBits;
  localparam int ColW     = oflc_pkg::ColumnBits;

  typedef struct packed {
    logic [OffW-1:0]     base;
    logic [OffW-1:0]     len;
    logic [LineIdxW-1:0] first;
    logic [LineCntW-1:0] lcnt;
  } rec_t;

  // latched item
  oflc_pkg::cmd_e              cmd_q;
  logic [oflc_pkg::ByteBits-1:0] byte_q;
  logic [OffW-1:0]             off_q;

  // table bookkeeping
  logic [FileCntW-1:0] file_count_q, file_count_d;
  logic [LineCntW-1:0] line_count_q, line_count_d;
  logic [OffW-1:0]     total_q, total_d;
  logic [OffW-1:0]     open_base_q, open_base_d;
  logic [OffW-1:0]     open_len_q, open_len_d;
  logic [LineIdxW-1:0] open_first_q, open_first_d;
  logic [LineCntW-1:0] open_lcnt_q, open_lcnt_d;

  // search unit
  logic [SrchW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [SrchW:0]      mid_w;
  logic [SrchW-1:0]    mid, lo_m1, lidx;
  logic [FileIdxW-1:0] f_q;
  logic [OffW-1:0]     local_q;
  logic [LineIdxW-1:0] first_q;
  logic [SrchW-1:0]    li_q;

  // results
  oflc_pkg::status_e res_status_q, ex_status;
  logic [IdW-1:0]    res_id_q;
  logic [LnW-1:0]    res_line_q;
  logic [ColW-1:0]   res_col_q;
  oflc_pkg::status_e out_status_q;
  logic [IdW-1:0]    out_id_q;
  logic [LnW-1:0]    out_line_q;
  logic [ColW-1:0]   out_col_q;
  logic              out_valid_q;

  // memories
  logic                rec_we, rec_re;
  logic [FileIdxW-1:0] rec_waddr, rec_raddr;
  rec_t                rec_wdata, rec_rd;
  logic                line_we, line_re;
  logic [LineIdxW-1:0] line_waddr, line_raddr;
  logic [OffW-1:0]     line_wdata, line_rd;

  logic [FileCntW-1:0] f_open;
  logic [31:0]         ex_id_w, fid_w, ln_w, laddr_w;
  logic [ColW-1:0]     col_w;
  logic                files_full, lines_full, total_full, is_nl;

  oflc_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_FILES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rd)
  );

  oflc_ram #(.WIDTH(OffW), .DEPTH(MAX_LINES)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rd)
  );

  assign mid_w = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
  assign mid   = mid_w[SrchW-1:0];
  assign lo_m1 = lo_q - 1'b1;

  assign stat_o.cmd       = cmd_q;
  assign stat_o.srch_done = (lo_q == hi_q);
  assign stat_o.lo_zero   = (lo_q == '0);
  assign stat_o.past_end  = ({1'b0, off_q} >= ({1'b0, rec_rd.base} + {1'b0, rec_rd.len}));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // read ports
  assign rec_re    = ctrl_i.f_read_mid || ctrl_i.f_read_last;
  assign rec_raddr = ctrl_i.f_read_last ? lo_m1[FileIdxW-1:0] : mid[FileIdxW-1:0];
  assign line_re   = ctrl_i.l_read_mid || ctrl_i.l_read_last;
  assign lidx      = ctrl_i.l_read_mid ? mid : (stat_o.lo_zero ? '0 : lo_m1);
  assign laddr_w   = 32'(first_q) + 32'(lidx);
  assign line_raddr = laddr_w[LineIdxW-1:0];

  assign f_open     = file_count_q - 1'b1;
  assign files_full = (file_count_q >= FileCntW'(MAX_FILES));
  assign lines_full = (line_count_q >= LineCntW'(MAX_LINES));
  assign total_full = (total_q == {OffW{1'b1}});
  assign is_nl      = (byte_q == oflc_pkg::NewlineByte);

  // begin-file and content-byte updates
  always_comb begin
    file_count_d = file_count_q;
    line_count_d = line_count_q;
    total_d      = total_q;
    open_base_d  = open_base_q;
    open_len_d   = open_len_q;
    open_first_d = open_first_q;
    open_lcnt_d  = open_lcnt_q;
    rec_we       = 1'b0;
    rec_waddr    = f_open[FileIdxW-1:0];
    rec_wdata    = '{base: open_base_q, len: open_len_q, first: open_first_q,
                     lcnt: open_lcnt_q};
    line_we      = 1'b0;
    line_waddr   = line_count_q[LineIdxW-1:0];
    line_wdata   = '0;
    ex_status    = oflc_pkg::ST_OK;
    ex_id_w      = '0;
    if (ctrl_i.exec) begin
      unique case (cmd_q)
        oflc_pkg::CMD_BEGIN: begin
          if (files_full || lines_full) begin
            ex_status = oflc_pkg::ST_FULL;
          end else begin
            ex_id_w      = 32'(file_count_q);
            open_base_d  = total_q;
            open_len_d   = '0;
            open_first_d = line_count_q[LineIdxW-1:0];
            open_lcnt_d  = LineCntW'(1);
            rec_we       = 1'b1;
            rec_waddr    = file_count_q[FileIdxW-1:0];
            rec_wdata    = '{base: open_base_d, len: open_len_d, first: open_first_d,
                             lcnt: open_lcnt_d};
            line_we      = 1'b1;
            file_count_d = file_count_q + 1'b1;
            line_count_d = line_count_q + 1'b1;
          end
        end
        oflc_pkg::CMD_BYTE: begin
          if (file_count_q == '0) begin
            ex_status = oflc_pkg::ST_NO_FILE;
          end else begin
            ex_id_w = 32'(f_open);
            if (total_full || (is_nl && lines_full)) begin
              ex_status = oflc_pkg::ST_FULL;
            end else begin
              if (is_nl) begin
                // next line starts right after the newline
                line_we      = 1'b1;
                line_wdata   = open_len_q + 1'b1;
                line_count_d = line_count_q + 1'b1;
                open_lcnt_d  = open_lcnt_q + 1'b1;
              end
              open_len_d = open_len_q + 1'b1;
              total_d    = total_q + 1'b1;
              rec_we     = 1'b1;
              rec_wdata  = '{base: open_base_q, len: open_len_d, first: open_first_q,
                             lcnt: open_lcnt_d};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // search bounds
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.fs_init) begin
      lo_d = '0;
      hi_d = SrchW'(file_count_q);
    end else if (ctrl_i.f_cmp) begin
      if (rec_rd.base <= off_q) begin
        lo_d = mid + 1'b1;
      end else begin
        hi_d = mid;
      end
    end else if (ctrl_i.ls_init) begin
      lo_d = '0;
      hi_d = SrchW'(rec_rd.lcnt);
    end else if (ctrl_i.l_cmp) begin
      if (line_rd <= local_q) begin
        lo_d = mid + 1'b1;
      end else begin
        hi_d = mid;
      end
    end
  end

  assign fid_w = 32'(f_q);
  assign ln_w  = 32'(li_q) + 32'd1;
  assign col_w = {1'b0, local_q} - {1'b0, line_rd} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_count_q <= '0;
      line_count_q <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      file_count_q <= file_count_d;
      line_count_q <= line_count_d;
      total_q      <= total_d;
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q  <= oflc_pkg::cmd_e'(in_user_i);
      byte_q <= in_data_i[oflc_pkg::ByteBits-1:0];
      off_q  <= in_data_i[oflc_pkg::ByteBits +: OffW];
    end
    open_base_q  <= open_base_d;
    open_len_q   <= open_len_d;
    open_first_q <= open_first_d;
    open_lcnt_q  <= open_lcnt_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    if (ctrl_i.ls_init) begin
      f_q     <= lo_m1[FileIdxW-1:0];
      local_q <= off_q - rec_rd.base;
      first_q <= rec_rd.first;
    end
    if (ctrl_i.l_read_last) begin
      li_q <= lidx;
    end
    if (ctrl_i.exec) begin
      res_status_q <= ex_status;
      res_id_q     <= ex_id_w[IdW-1:0];
      res_line_q   <= '0;
      res_col_q    <= '0;
    end else if (ctrl_i.set_nf) begin
      res_status_q <= oflc_pkg::ST_NOT_FOUND;
      res_id_q     <= '0;
      res_line_q   <= '0;
      res_col_q    <= '0;
    end else if (ctrl_i.set_ok) begin
      res_status_q <= oflc_pkg::ST_OK;
      res_id_q     <= fid_w[IdW-1:0];
      res_line_q   <= ln_w[LnW-1:0];
      res_col_q    <= col_w;
    end
    if (ctrl_i.load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_line_q   <= res_line_q;
      out_col_q    <= res_col_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_status_q;
  assign out_data_o  = {{oflc_pkg::OutPadBits{1'b0}}, out_col_q, out_line_q, out_id_q};

endmodule

>>> hdl/offset_to_file_line_column.sv
`timescale 1ns / 1ps

// Resolves global byte offsets of files laid end to end into file, line and column.
// Input channel s_axis: tuser is the command (begin file, content byte, lookup,
// unused), tdata carries the content byte and the lookup offset. Every command but
// the unused one gives exactly one result on m_axis: tuser is the status, tdata
// the file id, 1-based line and 1-based column (line and column zero unless a
// lookup succeeds).
// One item is worked at a time. Begin-file and content bytes pass through a decode
// state and a done state, which loads the result into the output register once it
// is free. A lookup runs two binary searches, each probe one read of a
// registered-read RAM plus a compare: first over the file records, then over the
// line starts of that file.
// Reset empties the tables at once (counts go to zero; the RAMs need no clearing).
// A stalled receiver holds the result in the output register; the block still
// takes and works the next item and then waits with its result until the
// register is taken.
module offset_to_file_line_column #(
  parameter int MAX_FILES = oflc_pkg::DefMaxFiles,
  parameter int MAX_LINES = oflc_pkg::DefMaxLines
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // data_byte [7:0], lookup_offset [31:8]
  input  logic [oflc_pkg::InDataBits-1:0]    s_axis_tdata,
  // cmd [1:0]
  input  logic [oflc_pkg::CmdBits-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // file_id [3:0], line_number [16:4], column [41:17], zero [47:42]
  output logic [oflc_pkg::OutDataBits-1:0]   m_axis_tdata,
  // status [1:0]
  output logic [oflc_pkg::StatusBits-1:0]    m_axis_tuser
);

  oflc_pkg::ctrl_cmd_t  ctrl;
  oflc_pkg::ctrl_stat_t stat;

  oflc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  oflc_dp #(
    .MAX_FILES (MAX_FILES),
    .MAX_LINES (MAX_LINES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  assign s_axis_tready = ctrl.in_ready;

endmodule

>>> hdl/oflc_chk.sv
`timescale 1ns / 1ps
`include "offset_to_file_line_column_defines.svh"

module oflc_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [oflc_pkg::OutDataBits-1:0] m_axis_tdata,
  input logic [oflc_pkg::StatusBits-1:0]  m_axis_tuser
);

  `OFLC_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "stalled result changed")
  `OFLC_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "item taken while busy")
  `OFLC_ASSERT(a_pos_zero, (m_axis_tvalid && (m_axis_tuser != oflc_pkg::ST_OK)) |-> (m_axis_tdata[41:4] == '0), "line or column set on a failed item")
  `OFLC_ASSERT(a_id_zero, (m_axis_tvalid && ((m_axis_tuser == oflc_pkg::ST_NOT_FOUND) || (m_axis_tuser == oflc_pkg::ST_NO_FILE))) |-> (m_axis_tdata[3:0] == '0), "file id set without a file")

endmodule

bind offset_to_file_line_column oflc_chk u_oflc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
